FILE: rtl/bls_pkg.sv
// shared types and constants for the bresenham line stepper
`timescale 1ns / 1ps

package bls_pkg;

  localparam int unsigned COLOR_BITS = 16;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef struct packed {
    logic x_major;
    logic x_negative;
    logic y_negative;
  } line_ctl_t;

endpackage

FILE: rtl/bls_setup.sv
// line setup: directions, major axis, error term, increments and step count
`timescale 1ns / 1ps

module bls_setup #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0]        x_start,
  input  logic [COORD_BITS-1:0]        y_start,
  input  logic [COORD_BITS-1:0]        x_end,
  input  logic [COORD_BITS-1:0]        y_end,
  output bls_pkg::line_ctl_t           ctl,
  output logic signed [COORD_BITS+1:0] err_init,
  output logic signed [COORD_BITS+1:0] minor_inc,
  output logic signed [COORD_BITS+1:0] diag_inc,
  output logic [COORD_BITS:0]          steps_init
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] d_major;
  logic [COORD_BITS-1:0] d_minor;
  logic [COORD_BITS+1:0] two_minor;
  logic [COORD_BITS+1:0] two_major;
  logic [COORD_BITS+1:0] one_major;

  always_comb begin
    ctl.x_negative = x_start > x_end;
    ctl.y_negative = y_start > y_end;
    dx = ctl.x_negative ? (x_start - x_end) : (x_end - x_start);
    dy = ctl.y_negative ? (y_start - y_end) : (y_end - y_start);
    ctl.x_major = dx >= dy;
    d_major = ctl.x_major ? dx : dy;
    d_minor = ctl.x_major ? dy : dx;
    two_minor = {1'b0, d_minor, 1'b0};
    two_major = {1'b0, d_major, 1'b0};
    one_major = {2'b00, d_major};
    minor_inc = two_minor;
    err_init = two_minor - one_major;
    diag_inc = two_minor - two_major;
    steps_init = {1'b0, d_major} + {{COORD_BITS{1'b0}}, 1'b1};
  end

endmodule

FILE: rtl/bls_stepper.sv
// line state registers and per-pixel error update
`timescale 1ns / 1ps

module bls_stepper #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic                               step,
  input  logic [COORD_BITS-1:0]              x_start,
  input  logic [COORD_BITS-1:0]              y_start,
  input  logic [bls_pkg::COLOR_BITS-1:0]     pen_color,
  input  logic                               dashed,
  input  bls_pkg::line_ctl_t                 ctl_init,
  input  logic signed [COORD_BITS+1:0]       err_init,
  input  logic signed [COORD_BITS+1:0]       minor_inc,
  input  logic signed [COORD_BITS+1:0]       diag_inc,
  input  logic [COORD_BITS:0]                steps_init,
  output logic [COORD_BITS-1:0]              pixel_x,
  output logic [COORD_BITS-1:0]              pixel_y,
  output logic [bls_pkg::COLOR_BITS-1:0]     pixel_color,
  output logic                               drawn,
  output logic                               last
);

  logic [COORD_BITS-1:0]          cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]          cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS+1:0]   err_r, err_nxt;
  logic signed [COORD_BITS+1:0]   minor_inc_r, minor_inc_nxt;
  logic signed [COORD_BITS+1:0]   diag_inc_r, diag_inc_nxt;
  logic [COORD_BITS:0]            steps_r, steps_nxt;
  logic                           parity_r, parity_nxt;
  bls_pkg::line_ctl_t             ctl_r, ctl_nxt;
  logic [bls_pkg::COLOR_BITS-1:0] color_r, color_nxt;
  logic                           dash_r, dash_nxt;
  logic                           active_r, active_nxt;

  logic                  move_x;
  logic                  move_y;
  logic [COORD_BITS-1:0] x_moved;
  logic [COORD_BITS-1:0] y_moved;
  logic                  final_pixel;

  always_comb begin
    final_pixel = steps_r <= {{COORD_BITS{1'b0}}, 1'b1};
    pixel_x     = active_r ? cur_x_r : '0;
    pixel_y     = active_r ? cur_y_r : '0;
    pixel_color = active_r ? color_r : '0;
    drawn       = active_r & ~(dash_r & parity_r);
    last        = ~active_r | final_pixel;

    move_x  = ~err_r[COORD_BITS+1] | ctl_r.x_major;
    move_y  = ~err_r[COORD_BITS+1] | ~ctl_r.x_major;
    x_moved = ctl_r.x_negative ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
    y_moved = ctl_r.y_negative ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);

    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    minor_inc_nxt = minor_inc_r;
    diag_inc_nxt  = diag_inc_r;
    steps_nxt     = steps_r;
    parity_nxt    = parity_r;
    ctl_nxt       = ctl_r;
    color_nxt     = color_r;
    dash_nxt      = dash_r;
    active_nxt    = active_r;

    if (load) begin
      cur_x_nxt     = x_start;
      cur_y_nxt     = y_start;
      err_nxt       = err_init;
      minor_inc_nxt = minor_inc;
      diag_inc_nxt  = diag_inc;
      steps_nxt     = steps_init;
      parity_nxt    = 1'b0;
      ctl_nxt       = ctl_init;
      color_nxt     = pen_color;
      dash_nxt      = dashed;
      active_nxt    = 1'b1;
    end else if (step && active_r) begin
      if (move_x) begin
        cur_x_nxt = x_moved;
      end
      if (move_y) begin
        cur_y_nxt = y_moved;
      end
      err_nxt    = err_r + (err_r[COORD_BITS+1] ? minor_inc_r : diag_inc_r);
      parity_nxt = ~parity_r;
      steps_nxt  = steps_r - {{COORD_BITS{1'b0}}, 1'b1};
      if (final_pixel) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      minor_inc_r <= '0;
      diag_inc_r  <= '0;
      steps_r     <= '0;
      parity_r    <= 1'b0;
      ctl_r       <= '0;
      color_r     <= '0;
      dash_r      <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      minor_inc_r <= minor_inc_nxt;
      diag_inc_r  <= diag_inc_nxt;
      steps_r     <= steps_nxt;
      parity_r    <= parity_nxt;
      ctl_r       <= ctl_nxt;
      color_r     <= color_nxt;
      dash_r      <= dash_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

FILE: rtl/bresenham_line_stepper_core.sv
// top level of the bresenham line stepper with dashed mode
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  action, endpoints, pen_color, dashed
//  out_     output     out_valid/out_stall pixel_x, pixel_y, pixel_color, drawn, last
//
//  one item per clock while in_stall is low; a step item's pixel shows on out_ the cycle after it is accepted
//  a load item gives no pixel
//  in_stall is high only while a pixel is held in the output register under out_stall
//  reset clears the line state (no line active) and the output valid
`timescale 1ns / 1ps

module bresenham_line_stepper_core #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [COORD_BITS-1:0]          in_x_start,
  input  logic [COORD_BITS-1:0]          in_y_start,
  input  logic [COORD_BITS-1:0]          in_x_end,
  input  logic [COORD_BITS-1:0]          in_y_end,
  input  logic [bls_pkg::COLOR_BITS-1:0] in_pen_color,
  input  logic                           in_dashed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic [bls_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                           out_drawn,
  output logic                           out_last
);

  logic in_fire;
  logic do_load;
  logic do_step;

  bls_pkg::line_ctl_t           setup_ctl;
  logic signed [COORD_BITS+1:0] setup_err;
  logic signed [COORD_BITS+1:0] setup_minor;
  logic signed [COORD_BITS+1:0] setup_diag;
  logic [COORD_BITS:0]          setup_steps;

  logic [COORD_BITS-1:0]          px;
  logic [COORD_BITS-1:0]          py;
  logic [bls_pkg::COLOR_BITS-1:0] pcolor;
  logic                           pdrawn;
  logic                           plast;

  logic                           out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0]          out_x_r;
  logic [COORD_BITS-1:0]          out_y_r;
  logic [bls_pkg::COLOR_BITS-1:0] out_color_r;
  logic                           out_drawn_r;
  logic                           out_last_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign do_load  = in_fire & (in_action == bls_pkg::ACT_LOAD);
  assign do_step  = in_fire & (in_action == bls_pkg::ACT_STEP);

  bls_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .x_start    (in_x_start),
    .y_start    (in_y_start),
    .x_end      (in_x_end),
    .y_end      (in_y_end),
    .ctl        (setup_ctl),
    .err_init   (setup_err),
    .minor_inc  (setup_minor),
    .diag_inc   (setup_diag),
    .steps_init (setup_steps)
  );

  bls_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (do_load),
    .step        (do_step),
    .x_start     (in_x_start),
    .y_start     (in_y_start),
    .pen_color   (in_pen_color),
    .dashed      (in_dashed),
    .ctl_init    (setup_ctl),
    .err_init    (setup_err),
    .minor_inc   (setup_minor),
    .diag_inc    (setup_diag),
    .steps_init  (setup_steps),
    .pixel_x     (px),
    .pixel_y     (py),
    .pixel_color (pcolor),
    .drawn       (pdrawn),
    .last        (plast)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_step) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_x_r     <= px;
      out_y_r     <= py;
      out_color_r <= pcolor;
      out_drawn_r <= pdrawn;
      out_last_r  <= plast;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_drawn       = out_drawn_r;
  assign out_last        = out_last_r;

endmodule

FILE: tb/bresenham_line_stepper_core_test.sv
// self-checking testbench for the bresenham line stepper core
`timescale 1ns / 1ps

module bresenham_line_stepper_core_test;

  localparam int unsigned CB = 10;
  localparam int COORD_MAX = 2**CB - 1;
  localparam int ITEM_TARGET = 1950;

  typedef logic [CB-1:0] coord_t;
  typedef logic [bls_pkg::COLOR_BITS-1:0] color_t;
  typedef logic signed [CB+1:0] err_t;
  typedef logic [CB:0] count_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   drawn;
    logic   last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t               expected_pixels[$];
    int                   mismatch_count = 0;
    coord_t               pos_x = '0;
    coord_t               pos_y = '0;
    logic signed [CB+1:0] err = '0;
    logic signed [CB+1:0] inc_straight = '0;
    logic signed [CB+1:0] inc_diag = '0;
    logic [CB:0]          left = '0;
    logic                 parity = 1'b0;
    logic                 major_x = 1'b0;
    logic                 neg_x = 1'b0;
    logic                 neg_y = 1'b0;
    logic                 dash_q = 1'b0;
    logic                 busy = 1'b0;
    color_t               color_q = '0;

    function void note_mismatch(string what);
      if (mismatch_count < 10) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
    endfunction

    function void note_item(bls_pkg::action_t act, coord_t xs, coord_t ys, coord_t xe,
                            coord_t ye, color_t color, logic dashed);
      pixel_t px;
      int     dx;
      int     dy;
      if (act == bls_pkg::ACT_LOAD) begin
        neg_x = xs > xe;
        neg_y = ys > ye;
        dx = neg_x ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
        dy = neg_y ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
        major_x = dx >= dy;
        if (major_x) begin
          inc_straight = err_t'(2 * dy);
          err = err_t'(2 * dy - dx);
          inc_diag = err_t'(2 * dy - 2 * dx);
          left = count_t'(dx + 1);
        end else begin
          inc_straight = err_t'(2 * dx);
          err = err_t'(2 * dx - dy);
          inc_diag = err_t'(2 * dx - 2 * dy);
          left = count_t'(dy + 1);
        end
        pos_x = xs;
        pos_y = ys;
        color_q = color;
        dash_q = dashed;
        parity = 1'b0;
        busy = 1'b1;
      end else begin
        px = '0;
        if (!busy) begin
          px.last = 1'b1;
        end else begin
          px.x = pos_x;
          px.y = pos_y;
          px.color = color_q;
          px.drawn = !(dash_q && parity);
          px.last = (left <= 1);
          if (err < 0) begin
            err = err + inc_straight;
            if (major_x) pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            else pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
          end else begin
            err = err + inc_diag;
            pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
            pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
          end
          parity = ~parity;
          if (left != 0) left = left - 1'b1;
          if (left == 0) busy = 1'b0;
        end
        expected_pixels.push_back(px);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h drawn=%b last=%b",
                                got.x, got.y, got.color, got.drawn, got.last));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.drawn !== want.drawn || got.last !== want.last)
        note_mismatch($sformatf({"pixel x=%0d y=%0d color=%h drawn=%b last=%b, ",
                                 "expected x=%0d y=%0d color=%h drawn=%b last=%b"},
                                got.x, got.y, got.color, got.drawn, got.last,
                                want.x, want.y, want.color, want.drawn, want.last));
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_action = 1'b0;
  coord_t in_x_start = '0;
  coord_t in_y_start = '0;
  coord_t in_x_end = '0;
  coord_t in_y_end = '0;
  color_t in_pen_color = '0;
  logic   in_dashed = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  color_t out_pixel_color;
  logic   out_drawn;
  logic   out_last;

  pixel_scoreboard sb;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  bresenham_line_stepper_core #(
    .COORD_BITS(CB)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_pen_color   (in_pen_color),
    .in_dashed      (in_dashed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_drawn      (out_drawn),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((stall_left % 16) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_pixel({out_pixel_x, out_pixel_y, out_pixel_color, out_drawn, out_last});
      if (in_valid && !in_stall)
        sb.note_item(bls_pkg::action_t'(in_action), in_x_start, in_y_start, in_x_end,
                     in_y_end, in_pen_color, in_dashed);
    end
  end

  task automatic send_item(bls_pkg::action_t act, coord_t xs, coord_t ys, coord_t xe,
                           coord_t ye, color_t color, logic dashed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_pen_color <= color;
    in_dashed <= dashed;
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // step payload is ignored, so it is random
  task automatic step_line(int n);
    repeat (n)
      send_item(bls_pkg::ACT_STEP, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), color_t'($urandom), 1'($urandom));
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return coord_t'(COORD_MAX);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t base, int span);
    int off;
    int t;
    off = $urandom_range(0, span);
    t = ($urandom_range(0, 1) == 1) ? int'(base) - off : int'(base) + off;
    if (t < 0 || t > COORD_MAX) t = (t < int'(base)) ? int'(base) + off : int'(base) - off;
    if (t < 0 || t > COORD_MAX) t = $urandom_range(0, COORD_MAX);
    return coord_t'(t);
  endfunction

  initial begin
    #10_000_000;
    $display("** bresenham_line_stepper_core: FAILED **");
    $finish;
  end

  initial begin
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    int     span;
    int     len;
    int     adx;
    int     ady;
    int     pick;
    int     settle;
    int     steps;
    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // step before any line, single pixel line, tie with reversed x and cut short,
    // steep line going up with dashes, shallow line at the far edge
    step_line(1);
    send_item(bls_pkg::ACT_LOAD, '0, '0, '0, '0, 16'h0000, 1'b0);
    step_line(2);
    send_item(bls_pkg::ACT_LOAD, coord_t'(COORD_MAX), '0, '0, coord_t'(COORD_MAX),
              16'hFFFF, 1'b1);
    step_line(3);
    send_item(bls_pkg::ACT_LOAD, coord_t'(5), coord_t'(10), coord_t'(8), coord_t'(2),
              16'hA5A5, 1'b1);
    step_line(10);
    send_item(bls_pkg::ACT_LOAD, '0, coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX - 3), 16'h5A5A, 1'b0);
    step_line(2);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(bls_pkg::action_t'($urandom_range(0, 1)), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  color_t'($urandom), 1'($urandom));
      end else begin
        xs = pick_coord();
        ys = pick_coord();
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          xe = pick_coord();
          ye = pick_coord();
        end else begin
          span = (pick < 12) ? 100 : 12;
          xe = near_coord(xs, span);
          ye = near_coord(ys, span);
        end
        send_item(bls_pkg::ACT_LOAD, xs, ys, xe, ye, color_t'($urandom), 1'($urandom));
        adx = (xs > xe) ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
        ady = (ys > ye) ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
        len = ((adx > ady) ? adx : ady) + 1;
        pick = $urandom_range(0, 99);
        if (pick < 78) steps = len;
        else if (pick < 88) steps = len + int'($urandom_range(1, 3));
        else steps = int'($urandom_range(0, len - 1));
        // keep the total near the target, the last line may be cut short
        if (steps > ITEM_TARGET - items_sent) steps = ITEM_TARGET - items_sent;
        step_line(steps);
      end
    end

    in_valid <= 1'b0;
    settle = 0;
    while (sb.expected_pixels.size() != 0 && settle < 10000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (sb.expected_pixels.size() != 0)
      sb.note_mismatch($sformatf("%0d pixels never arrived", sb.expected_pixels.size()));
    if (sb.mismatch_count == 0) begin
      $display("** bresenham_line_stepper_core: PASSED **");
    end else begin
      $display("** bresenham_line_stepper_core: FAILED **");
    end
    $finish;
  end

endmodule
